/* sv/ray_cylinder_nearest_hit_macros.svh */
// Assertion macros for the ray/cylinder nearest-hit block.
// Used by the port checker; expects clock and reset in scope.
`ifndef RAY_CYLINDER_NEAREST_HIT_MACROS_SVH
`define RAY_CYLINDER_NEAREST_HIT_MACROS_SVH

// same-cycle implication
`define RCN_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rcn checker: same-cycle property violated");

// next-cycle implication
`define RCN_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rcn checker: next-cycle property violated");

`endif

/* sv/rcn_pkg.sv */
// Shared types, constants, micro-program and Q16.16 helpers for the
// ray/cylinder nearest-hit block. No dependencies.
package rcn_pkg;

   localparam int RCN_MAX_CYLINDERS = 16;
   localparam int DIV_STEPS  = 48;
   localparam int SQRT_STEPS = 32;
   localparam int PC_W       = 6;

   localparam logic signed [31:0] DISC_MIN = 32'sd66;
   localparam logic signed [31:0] T_MIN    = 32'sd6553;

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_TRACE = 1'b1
   } op_type;

   typedef enum logic [4:0] {
      A_NONE, A_LOAD, A_START, A_SUBS, A_L2_FIRST, A_L2_ADD, A_SQRT_L2, A_DIV,
      A_WR_UN, A_ACC_FIRST, A_ACC_ADD, A_DOT_END, A_FMUL, A_ABC, A_DISC,
      A_SQRT_DISC, A_N01, A_WR_T, A_PICK
   } act_type;

   typedef enum logic [4:0] {
      M_NONE, M_UU0, M_UU1, M_UU2, M_DD0, M_DD1, M_DD2, M_DUN0, M_DUN1, M_DUN2,
      M_DS0, M_DS1, M_DS2, M_SUN0, M_SUN1, M_SUN2, M_SS0, M_SS1, M_SS2,
      M_DUDU, M_DUSU, M_SUSU, M_RR, M_BB, M_AC
   } mul_sel_type;

   typedef enum logic [3:0] {
      R_DD, R_DU, R_DS, R_SU, R_SS, R_DU2, R_DUSU, R_SU2, R_RR, R_BB, R_AC,
      R_UN0, R_UN1, R_UN2, R_T0, R_T1
   } reg_type;

   typedef enum logic [2:0] {
      D_U0, D_U1, D_U2, D_N0, D_N1
   } div_src_type;

   typedef struct packed {
      mul_sel_type mul;
      act_type     act;
      reg_type     dst;
      div_src_type src;
      logic        hold;
      logic        br;
      logic        last;
   } uop_type;

   typedef struct packed {
      act_type     act;
      mul_sel_type mul;
      reg_type     dst;
      div_src_type src;
   } cmd_type;

   typedef struct packed {
      logic busy;
      logic reject;
   } stat_type;

   typedef struct packed {
      logic signed [31:0] bx;
      logic signed [31:0] by;
      logic signed [31:0] bz;
      logic signed [31:0] ax;
      logic signed [31:0] ay;
      logic signed [31:0] az;
      logic [30:0]        r;
   } cyl_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      logic signed [31:0] res;
      if (x > 64'sh0000_0000_7FFF_FFFF) res = 32'sh7FFF_FFFF;
      else if (x < -64'sh0000_0000_8000_0000) res = 32'sh8000_0000;
      else res = x[31:0];
      return res;
   endfunction

   function automatic logic signed [31:0] fsub(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
      return sat32(64'(a) - 64'(b));
   endfunction

   // per-cylinder micro-program
   function automatic uop_type rcn_rom(input logic [PC_W-1:0] pc);
      uop_type u;
      u = '{M_NONE, A_NONE, R_DD, D_U0, 1'b0, 1'b0, 1'b0};
      unique case (pc)
         6'd0:  u.act = A_SUBS;
         6'd1:  u.mul = M_UU0;
         6'd2:  begin u.mul = M_UU1; u.act = A_L2_FIRST; end
         6'd3:  begin u.mul = M_UU2; u.act = A_L2_ADD; end
         6'd4:  u.act = A_L2_ADD;
         6'd5:  begin u.act = A_SQRT_L2; u.hold = 1'b1; end
         6'd6:  begin u.act = A_DIV; u.src = D_U0; u.hold = 1'b1; end
         6'd7:  begin u.act = A_WR_UN; u.dst = R_UN0; end
         6'd8:  begin u.act = A_DIV; u.src = D_U1; u.hold = 1'b1; end
         6'd9:  begin u.act = A_WR_UN; u.dst = R_UN1; end
         6'd10: begin u.act = A_DIV; u.src = D_U2; u.hold = 1'b1; end
         6'd11: begin u.act = A_WR_UN; u.dst = R_UN2; end
         6'd12: u.mul = M_DD0;
         6'd13: begin u.mul = M_DD1; u.act = A_ACC_FIRST; end
         6'd14: begin u.mul = M_DD2; u.act = A_ACC_ADD; end
         6'd15: begin u.mul = M_DUN0; u.act = A_DOT_END; u.dst = R_DD; end
         6'd16: begin u.mul = M_DUN1; u.act = A_ACC_FIRST; end
         6'd17: begin u.mul = M_DUN2; u.act = A_ACC_ADD; end
         6'd18: begin u.mul = M_DS0; u.act = A_DOT_END; u.dst = R_DU; end
         6'd19: begin u.mul = M_DS1; u.act = A_ACC_FIRST; end
         6'd20: begin u.mul = M_DS2; u.act = A_ACC_ADD; end
         6'd21: begin u.mul = M_SUN0; u.act = A_DOT_END; u.dst = R_DS; end
         6'd22: begin u.mul = M_SUN1; u.act = A_ACC_FIRST; end
         6'd23: begin u.mul = M_SUN2; u.act = A_ACC_ADD; end
         6'd24: begin u.mul = M_SS0; u.act = A_DOT_END; u.dst = R_SU; end
         6'd25: begin u.mul = M_SS1; u.act = A_ACC_FIRST; end
         6'd26: begin u.mul = M_SS2; u.act = A_ACC_ADD; end
         6'd27: begin u.mul = M_DUDU; u.act = A_DOT_END; u.dst = R_SS; end
         6'd28: begin u.mul = M_DUSU; u.act = A_FMUL; u.dst = R_DU2; end
         6'd29: begin u.mul = M_SUSU; u.act = A_FMUL; u.dst = R_DUSU; end
         6'd30: begin u.mul = M_RR; u.act = A_FMUL; u.dst = R_SU2; end
         6'd31: begin u.act = A_FMUL; u.dst = R_RR; end
         6'd32: u.act = A_ABC;
         6'd33: u.mul = M_BB;
         6'd34: begin u.mul = M_AC; u.act = A_FMUL; u.dst = R_BB; end
         6'd35: begin u.act = A_FMUL; u.dst = R_AC; end
         6'd36: u.act = A_DISC;
         6'd37: begin u.act = A_SQRT_DISC; u.hold = 1'b1; u.br = 1'b1; end
         6'd38: u.act = A_N01;
         6'd39: begin u.act = A_DIV; u.src = D_N0; u.hold = 1'b1; end
         6'd40: begin u.act = A_WR_T; u.dst = R_T0; end
         6'd41: begin u.act = A_DIV; u.src = D_N1; u.hold = 1'b1; end
         6'd42: begin u.act = A_WR_T; u.dst = R_T1; end
         6'd43: begin u.act = A_PICK; u.last = 1'b1; end
         default: u.last = 1'b1;
      endcase
      return u;
   endfunction

endpackage

/* sv/rcn_sqrt.sv */
// Bit-serial integer square root, two radicand bits per cycle.
// Depends on rcn_pkg.
module rcn_sqrt
   import rcn_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        busy,
   output logic [31:0] root
);

   logic [63:0] v_ff, v_in;
   logic [34:0] rem_ff, rem_in;
   logic [31:0] res_ff, res_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [34:0] trial_rem, trial;
   logic        ge;

   always_comb begin
      trial_rem = {rem_ff[32:0], v_ff[63:62]};
      trial     = {1'b0, res_ff, 2'b01};
      ge        = trial_rem >= trial;
      v_in      = v_ff;
      rem_in    = rem_ff;
      res_in    = res_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      if (start) begin
         v_in    = radicand;
         rem_in  = '0;
         res_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         v_in   = {v_ff[61:0], 2'b00};
         rem_in = ge ? trial_rem - trial : trial_rem;
         res_in = {res_ff[30:0], ge};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(SQRT_STEPS - 1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      v_ff   <= v_in;
      rem_ff <= rem_in;
      res_ff <= res_in;
   end

   assign busy = busy_ff;
   assign root = res_ff;

endmodule

/* sv/rcn_div.sv */
// Restoring divider: (num * 2^16) / den, truncated toward zero, saturated.
// One quotient bit per cycle. Depends on rcn_pkg.
module rcn_div
   import rcn_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] num,
   input  logic [31:0]        den_mag,
   input  logic               den_neg,
   output logic               busy,
   output logic signed [31:0] quot
);

   logic [47:0] q_ff, q_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic        neg_ff, neg_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [32:0] trial;
   logic        ge;
   logic [31:0] num_mag;

   always_comb begin
      num_mag = num[31] ? 32'(-33'(num)) : 32'(num);
      trial   = {rem_ff[31:0], q_ff[47]};
      ge      = trial >= {1'b0, den_ff};
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         q_in    = {num_mag, 16'h0000};
         rem_in  = '0;
         den_in  = den_mag;
         neg_in  = num[31] ^ den_neg;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? trial - {1'b0, den_ff} : trial;
         q_in   = {q_ff[46:0], ge};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(DIV_STEPS - 1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   always_comb begin
      if (!neg_ff) begin
         quot = (q_ff > 48'h0000_7FFF_FFFF) ? 32'sh7FFF_FFFF : signed'(q_ff[31:0]);
      end else begin
         quot = (q_ff > 48'h0000_8000_0000) ? 32'sh8000_0000 : signed'(-q_ff[31:0]);
      end
   end

   assign busy = busy_ff;

endmodule

/* sv/rcn_datapath.sv */
// Datapath: cylinder memory, operand registers, one 32x32 multiplier,
// shared square-root and divider units. Depends on rcn_pkg, rcn_sqrt, rcn_div.
module rcn_datapath
   import rcn_pkg::*;
#(
   parameter int MAX_CYLINDERS = RCN_MAX_CYLINDERS,
   localparam int IDX_W = (MAX_CYLINDERS > 1) ? $clog2(MAX_CYLINDERS) : 1
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   input  logic [IDX_W-1:0]   cyl_addr,
   output stat_type           status,
   input  logic [3:0]         req_slot,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   input  logic signed [31:0] req_point_z,
   input  logic signed [31:0] req_vector_x,
   input  logic signed [31:0] req_vector_y,
   input  logic signed [31:0] req_vector_z,
   input  logic [30:0]        req_radius,
   input  logic [30:0]        req_prior_distance,
   output logic               rsp_hit,
   output logic [3:0]         rsp_cylinder_index,
   output logic [30:0]        rsp_distance
);

   cyl_type tab_ff [MAX_CYLINDERS];
   cyl_type rd_ff;

   logic signed [31:0] st_ff [3];
   logic signed [31:0] d_ff  [3];
   logic signed [31:0] u_ff  [3];
   logic signed [31:0] s_ff  [3];
   logic signed [31:0] sc_ff [16];
   logic [63:0]        l2_ff;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [49:0] acc_ff;
   logic signed [31:0] a_ff, b_ff, c_ff, disc_ff, den_ff, nb_ff, n0_ff, n1_ff;
   logic signed [31:0] best_ff;
   logic               hit_ff;
   logic [3:0]         idx_ff;

   logic signed [31:0] ma, mb, rad_s;
   logic               slot_ok, reject;
   logic               sqrt_start, sqrt_busy, div_start, div_busy;
   logic [63:0]        sqrt_v;
   logic [31:0]        sq_root;
   logic signed [31:0] sq_s;
   logic signed [31:0] div_num, div_q, t0, t1;
   logic [31:0]        div_den;
   logic               div_neg, ok0, ok1;

   assign slot_ok = int'(req_slot) < MAX_CYLINDERS;
   assign rad_s   = signed'({1'b0, rd_ff.r});
   assign reject  = (disc_ff < DISC_MIN) || (den_ff == 32'sd0);
   assign status  = '{busy: sqrt_busy | div_busy, reject: reject};

   always_comb begin
      ma = '0;
      mb = '0;
      unique case (cmd.mul)
         M_NONE: ;
         M_UU0:  begin ma = u_ff[0]; mb = u_ff[0]; end
         M_UU1:  begin ma = u_ff[1]; mb = u_ff[1]; end
         M_UU2:  begin ma = u_ff[2]; mb = u_ff[2]; end
         M_DD0:  begin ma = d_ff[0]; mb = d_ff[0]; end
         M_DD1:  begin ma = d_ff[1]; mb = d_ff[1]; end
         M_DD2:  begin ma = d_ff[2]; mb = d_ff[2]; end
         M_DUN0: begin ma = d_ff[0]; mb = sc_ff[R_UN0]; end
         M_DUN1: begin ma = d_ff[1]; mb = sc_ff[R_UN1]; end
         M_DUN2: begin ma = d_ff[2]; mb = sc_ff[R_UN2]; end
         M_DS0:  begin ma = d_ff[0]; mb = s_ff[0]; end
         M_DS1:  begin ma = d_ff[1]; mb = s_ff[1]; end
         M_DS2:  begin ma = d_ff[2]; mb = s_ff[2]; end
         M_SUN0: begin ma = s_ff[0]; mb = sc_ff[R_UN0]; end
         M_SUN1: begin ma = s_ff[1]; mb = sc_ff[R_UN1]; end
         M_SUN2: begin ma = s_ff[2]; mb = sc_ff[R_UN2]; end
         M_SS0:  begin ma = s_ff[0]; mb = s_ff[0]; end
         M_SS1:  begin ma = s_ff[1]; mb = s_ff[1]; end
         M_SS2:  begin ma = s_ff[2]; mb = s_ff[2]; end
         M_DUDU: begin ma = sc_ff[R_DU]; mb = sc_ff[R_DU]; end
         M_DUSU: begin ma = sc_ff[R_DU]; mb = sc_ff[R_SU]; end
         M_SUSU: begin ma = sc_ff[R_SU]; mb = sc_ff[R_SU]; end
         M_RR:   begin ma = rad_s; mb = rad_s; end
         M_BB:   begin ma = b_ff; mb = b_ff; end
         M_AC:   begin ma = a_ff; mb = c_ff; end
         default: ;
      endcase
      prod_in = 64'(ma) * 64'(mb);
   end

   // square root and divider operands, and the tests of both roots against best
   always_comb begin
      sqrt_start = (cmd.act == A_SQRT_L2) || ((cmd.act == A_SQRT_DISC) && !reject);
      sqrt_v     = (cmd.act == A_SQRT_L2) ? l2_ff : 64'({disc_ff, 16'h0000});
      sq_s       = signed'(sq_root);
      div_start  = cmd.act == A_DIV;
      div_num    = u_ff[0];
      div_den    = sq_root;
      div_neg    = 1'b0;
      case (cmd.src)
         D_U0: div_num = u_ff[0];
         D_U1: div_num = u_ff[1];
         D_U2: div_num = u_ff[2];
         D_N0, D_N1: begin
            div_num = (cmd.src == D_N0) ? n0_ff : n1_ff;
            div_neg = den_ff[31];
            div_den = den_ff[31] ? 32'(-33'(den_ff)) : 32'(den_ff);
         end
         default: ;
      endcase
      t0  = sc_ff[R_T0];
      t1  = sc_ff[R_T1];
      ok0 = (t0 > T_MIN) && (t0 < best_ff);
      ok1 = (t1 > T_MIN) && (t1 < best_ff);
   end

   rcn_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sqrt_v),
      .busy     (sqrt_busy),
      .root     (sq_root)
   );

   rcn_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .num     (div_num),
      .den_mag (div_den),
      .den_neg (div_neg),
      .busy    (div_busy),
      .quot    (div_q)
   );

   // cylinder memory: one write port, registered read
   always_ff @(posedge clock) begin
      if (cmd.act == A_LOAD && slot_ok) begin
         tab_ff[IDX_W'(req_slot)] <= '{bx: req_point_x, by: req_point_y, bz: req_point_z,
                                       ax: req_vector_x, ay: req_vector_y,
                                       az: req_vector_z, r: req_radius};
      end
      rd_ff <= tab_ff[cyl_addr];
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      case (cmd.act)
         A_START: begin
            st_ff[0] <= req_point_x;
            st_ff[1] <= req_point_y;
            st_ff[2] <= req_point_z;
            d_ff[0]  <= req_vector_x;
            d_ff[1]  <= req_vector_y;
            d_ff[2]  <= req_vector_z;
            best_ff  <= signed'({1'b0, req_prior_distance});
         end
         A_SUBS: begin
            u_ff[0] <= fsub(rd_ff.bx, rd_ff.ax);
            u_ff[1] <= fsub(rd_ff.by, rd_ff.ay);
            u_ff[2] <= fsub(rd_ff.bz, rd_ff.az);
            s_ff[0] <= fsub(st_ff[0], rd_ff.ax);
            s_ff[1] <= fsub(st_ff[1], rd_ff.ay);
            s_ff[2] <= fsub(st_ff[2], rd_ff.az);
         end
         A_L2_FIRST:  l2_ff <= prod_ff;
         A_L2_ADD:    l2_ff <= l2_ff + prod_ff;
         A_WR_UN:     sc_ff[cmd.dst] <= (sq_root == 32'd0) ? 32'sd0 : div_q;
         A_ACC_FIRST: acc_ff <= 50'(prod_ff >>> 16);
         A_ACC_ADD:   acc_ff <= acc_ff + 50'(prod_ff >>> 16);
         A_DOT_END:   sc_ff[cmd.dst] <= sat32(64'(acc_ff + 50'(prod_ff >>> 16)));
         A_FMUL:      sc_ff[cmd.dst] <= sat32(prod_ff >>> 16);
         A_ABC: begin
            a_ff <= fsub(sc_ff[R_DD], sc_ff[R_DU2]);
            b_ff <= fsub(sat32(64'(sc_ff[R_DS]) <<< 1), sat32(64'(sc_ff[R_DUSU]) <<< 1));
            c_ff <= fsub(fsub(sc_ff[R_SS], sc_ff[R_SU2]), sc_ff[R_RR]);
         end
         A_DISC: begin
            disc_ff <= fsub(sc_ff[R_BB], sat32(64'(sc_ff[R_AC]) <<< 2));
            den_ff  <= sat32(64'(a_ff) <<< 1);
            nb_ff   <= sat32(-64'(b_ff));
         end
         A_N01: begin
            n0_ff <= fsub(nb_ff, sq_s);
            n1_ff <= sat32(64'(nb_ff) + 64'(sq_s));
         end
         A_WR_T:      sc_ff[cmd.dst] <= div_q;
         A_PICK: begin
            if (ok0) best_ff <= t0;
            else if (ok1) best_ff <= t1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
         idx_ff <= '0;
      end else if (cmd.act == A_START) begin
         hit_ff <= 1'b0;
         idx_ff <= '0;
      end else if (cmd.act == A_PICK && (ok0 || ok1)) begin
         hit_ff <= 1'b1;
         idx_ff <= 4'(cyl_addr);
      end
   end

   assign rsp_hit            = hit_ff;
   assign rsp_cylinder_index = idx_ff;
   assign rsp_distance       = best_ff[30:0];

endmodule

/* sv/rcn_ctrl.sv */
// Controller: request handshake, cylinder count register, cylinder loop
// and micro-program sequencer. Depends on rcn_pkg.
module rcn_ctrl
   import rcn_pkg::*;
#(
   parameter int MAX_CYLINDERS = RCN_MAX_CYLINDERS,
   localparam int IDX_W = (MAX_CYLINDERS > 1) ? $clog2(MAX_CYLINDERS) : 1,
   localparam int KW    = $clog2(MAX_CYLINDERS + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_operation,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  logic             csr_write_enable,
   input  logic [4:0]       csr_write_data,
   output cmd_type          cmd,
   output logic [IDX_W-1:0] cyl_addr,
   input  stat_type         status
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_READ = 5'b00010,
      ST_RUN  = 5'b00100,
      ST_WAIT = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [PC_W-1:0]  pc_ff, pc_in;
   logic [KW-1:0]    k_ff, k_in, k_next, n_eff;
   logic [4:0]       count_ff;
   uop_type          uop;

   assign n_eff    = (int'(count_ff) > MAX_CYLINDERS) ? KW'(MAX_CYLINDERS) : KW'(count_ff);
   assign k_next   = k_ff + KW'(1);
   assign cyl_addr = k_ff[IDX_W-1:0];
   assign uop      = rcn_rom(pc_ff);

   always_comb begin
      state_in  = state_ff;
      pc_in     = pc_ff;
      k_in      = k_ff;
      cmd       = '{A_NONE, M_NONE, R_DD, D_U0};
      req_ready = state_ff == ST_IDLE;
      rsp_valid = state_ff == ST_OUT;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (op_type'(req_operation) == OP_LOAD) begin
                  cmd.act = A_LOAD;
               end else begin
                  cmd.act  = A_START;
                  k_in     = '0;
                  state_in = (n_eff == '0) ? ST_OUT : ST_READ;
               end
            end
         end
         ST_READ: begin
            pc_in    = '0;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            cmd = '{uop.act, uop.mul, uop.dst, uop.src};
            if ((uop.br && status.reject) || (uop.last && !uop.hold)) begin
               // drop or finish this cylinder
               k_in     = k_next;
               state_in = (k_next == n_eff) ? ST_OUT : ST_READ;
            end else if (uop.hold) begin
               state_in = ST_WAIT;
            end else begin
               pc_in = pc_ff + PC_W'(1);
            end
         end
         ST_WAIT: begin
            if (!status.busy) begin
               pc_in    = pc_ff + PC_W'(1);
               state_in = ST_RUN;
            end
         end
         ST_OUT: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pc_ff    <= '0;
         k_ff     <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         k_ff     <= k_in;
         if (csr_write_enable) count_ff <= csr_write_data;
      end
   end

endmodule

/* sv/ray_cylinder_nearest_hit.sv */
// Nearest hit of a ray against up to MAX_CYLINDERS infinite cylinders, Q16.16.
// Depends on rcn_pkg, rcn_ctrl and rcn_datapath.
//
// A load request (operation 0) stores one cylinder in a slot and gives no
// response. A trace request (operation 1) tests the first cylinder_count stored
// cylinders (at most MAX_CYLINDERS) in order and gives one response. The block
// handles one request at a time. Per cylinder the trace spends one table read,
// 44 micro-program steps around one 32x32 multiplier, and waits on each of five
// bit-serial divisions and on each of two square roots. A cylinder that the
// discriminant or denominator rejects leaves after 38 steps, one square root and
// three divisions. When no cylinder is tested, the response is valid in the
// cycle after the request is accepted. The user must write cylinder_count
// through csr_write_enable only while no trace is in flight; the block does not
// enforce this.
module ray_cylinder_nearest_hit
   import rcn_pkg::*;
#(
   parameter int MAX_CYLINDERS = RCN_MAX_CYLINDERS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_operation,
   input  logic [3:0]         req_slot,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   input  logic signed [31:0] req_point_z,
   input  logic signed [31:0] req_vector_x,
   input  logic signed [31:0] req_vector_y,
   input  logic signed [31:0] req_vector_z,
   input  logic [30:0]        req_radius,
   input  logic [30:0]        req_prior_distance,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_hit,
   output logic [3:0]         rsp_cylinder_index,
   output logic [30:0]        rsp_distance,
   input  logic               csr_write_enable,
   input  logic [4:0]         csr_write_data
);

   localparam int IDX_W = (MAX_CYLINDERS > 1) ? $clog2(MAX_CYLINDERS) : 1;

   cmd_type          cmd;
   stat_type         status;
   logic [IDX_W-1:0] cyl_addr;

   rcn_ctrl #(.MAX_CYLINDERS(MAX_CYLINDERS)) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .cyl_addr         (cyl_addr),
      .status           (status)
   );

   rcn_datapath #(.MAX_CYLINDERS(MAX_CYLINDERS)) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .cyl_addr           (cyl_addr),
      .status             (status),
      .req_slot           (req_slot),
      .req_point_x        (req_point_x),
      .req_point_y        (req_point_y),
      .req_point_z        (req_point_z),
      .req_vector_x       (req_vector_x),
      .req_vector_y       (req_vector_y),
      .req_vector_z       (req_vector_z),
      .req_radius         (req_radius),
      .req_prior_distance (req_prior_distance),
      .rsp_hit            (rsp_hit),
      .rsp_cylinder_index (rsp_cylinder_index),
      .rsp_distance       (rsp_distance)
   );

endmodule

/* sv/rcn_checker.sv */
// Port checker for the ray/cylinder nearest-hit block, bound to the top level.
// Depends on ray_cylinder_nearest_hit_macros.svh.
`include "ray_cylinder_nearest_hit_macros.svh"

module rcn_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               req_operation,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_hit,
   input logic [3:0]         rsp_cylinder_index,
   input logic [30:0]        rsp_distance
);

   `RCN_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_distance))
   `RCN_ASSERT_NOW(a_idx_zero_on_miss, rsp_valid && !rsp_hit, rsp_cylinder_index == 4'd0)
   `RCN_ASSERT_NOW(a_hit_beyond_min, rsp_valid && rsp_hit, rsp_distance > 31'd6553)
   `RCN_ASSERT_NEXT(a_load_silent, req_valid && req_ready && !req_operation, !rsp_valid)
   `RCN_ASSERT_NOW(a_one_at_a_time, rsp_valid, !req_ready)

endmodule

bind ray_cylinder_nearest_hit rcn_checker u_checker (.*);

/* dv/ray_cylinder_nearest_hit_tb.sv */
// Testbench for ray_cylinder_nearest_hit: load and trace requests with random idling,
// checked against a Q16.16 cylinder-intersection predictor. Uses rcn_pkg and the DUT.
module ray_cylinder_nearest_hit_tb
   import rcn_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_SLOTS  = 16;
   localparam int ONE        = 65536;
   localparam int DISC_FLOOR = 66;
   localparam int T_FLOOR    = 6553;
   localparam int WATCHDOG   = 200000;
   localparam int DRAIN      = 20;

   typedef logic signed [31:0] q16_type;

   typedef struct {
      op_type      op;
      logic [3:0]  slot;
      q16_type     px, py, pz, vx, vy, vz;
      logic [30:0] radius;
      logic [30:0] prior;
   } request_type;

   typedef struct {
      logic        hit;
      logic [3:0]  idx;
      logic [30:0] distance;
   } hit_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0, req_ready;
   logic req_operation = 1'b0;
   logic [3:0] req_slot = '0;
   q16_type req_point_x = '0, req_point_y = '0, req_point_z = '0;
   q16_type req_vector_x = '0, req_vector_y = '0, req_vector_z = '0;
   logic [30:0] req_radius = '0, req_prior_distance = '0;
   logic rsp_valid, rsp_ready = 1'b0, rsp_hit;
   logic [3:0] rsp_cylinder_index;
   logic [30:0] rsp_distance;
   logic csr_write_enable = 1'b0;
   logic [4:0] csr_write_data = '0;

   request_type    pending_requests[$];
   hit_result_type expected_hits[$];
   cyl_type        cyl_table[NUM_SLOTS];
   logic [4:0]     cyl_count;
   int             pushed = 0, accepted = 0, errors = 0, idle_cycles = 0;
   int             send_idle_pct = 0, recv_stall_pct = 0;
   bit             req_taken = 1'b0;

   ray_cylinder_nearest_hit u_top (
      .clock, .reset, .req_valid, .req_ready, .req_operation, .req_slot,
      .req_point_x, .req_point_y, .req_point_z, .req_vector_x, .req_vector_y,
      .req_vector_z, .req_radius, .req_prior_distance, .rsp_valid, .rsp_ready,
      .rsp_hit, .rsp_cylinder_index, .rsp_distance, .csr_write_enable, .csr_write_data
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------- Q16.16 predictor ----------------
   function automatic q16_type clip32(input longint x);
      if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (x < -64'sd2147483648) return 32'sh8000_0000;
      return q16_type'(x);
   endfunction

   function automatic q16_type q_sub(input q16_type a, input q16_type b);
      return clip32(longint'(a) - longint'(b));
   endfunction

   function automatic q16_type q_mul(input q16_type a, input q16_type b);
      return clip32((longint'(a) * longint'(b)) >>> 16);
   endfunction

   function automatic q16_type q_dot(input q16_type x[3], input q16_type y[3]);
      longint acc;
      acc = 0;
      for (int i = 0; i < 3; i++) acc += (longint'(x[i]) * longint'(y[i])) >>> 16;
      return clip32(acc);
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned res, bits;
      res = 0;
      bits = 64'd1 << 62;
      while (bits > v) bits >>= 2;
      while (bits != 0) begin
         if (v >= res + bits) begin
            v -= res + bits;
            res = (res >> 1) + bits;
         end else begin
            res >>= 1;
         end
         bits >>= 2;
      end
      return res;
   endfunction

   // Return 1 with the new distance when cylinder k beats best.
   function automatic bit cylinder_closer(input int k, input request_type rq,
                                          input q16_type best, output q16_type t_new);
      q16_type ap[3], u[3], un[3], s[3], st[3], d[3];
      q16_type dd, du, ds, su, ss, a, b, c, disc, sq, den, nb, t0, t1, r;
      longint unsigned l2;
      longint len;
      cyl_type cy;
      cy = cyl_table[k];
      t_new = '0;
      ap = '{cy.ax, cy.ay, cy.az};
      u  = '{q_sub(cy.bx, cy.ax), q_sub(cy.by, cy.ay), q_sub(cy.bz, cy.az)};
      st = '{rq.px, rq.py, rq.pz};
      d  = '{rq.vx, rq.vy, rq.vz};
      l2 = 0;
      for (int i = 0; i < 3; i++) l2 += longint'(u[i]) * longint'(u[i]);
      len = longint'(int_sqrt(l2));
      for (int i = 0; i < 3; i++) begin
         un[i] = (len == 0) ? '0 : clip32((longint'(u[i]) * 65536) / len);
         s[i] = q_sub(st[i], ap[i]);
      end
      dd = q_dot(d, d);
      du = q_dot(d, un);
      ds = q_dot(d, s);
      su = q_dot(s, un);
      ss = q_dot(s, s);
      r  = q16_type'({1'b0, cy.r});
      a = q_sub(dd, q_mul(du, du));
      b = q_sub(clip32(2 * longint'(ds)), clip32(2 * longint'(q_mul(du, su))));
      c = q_sub(q_sub(ss, q_mul(su, su)), q_mul(r, r));
      disc = q_sub(q_mul(b, b), clip32(4 * longint'(q_mul(a, c))));
      if (disc < DISC_FLOOR) return 1'b0;
      sq = q16_type'(int_sqrt(longint'(disc) << 16));
      den = clip32(2 * longint'(a));
      if (den == 0) return 1'b0;
      nb = clip32(-longint'(b));
      t0 = clip32((longint'(q_sub(nb, sq)) * 65536) / longint'(den));
      t1 = clip32((longint'(clip32(longint'(nb) + longint'(sq))) * 65536) / longint'(den));
      if (t0 > T_FLOOR && t0 < best) begin
         t_new = t0;
         return 1'b1;
      end
      if (t1 > T_FLOOR && t1 < best) begin
         t_new = t1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic predict_request(input request_type rq);
      hit_result_type res;
      q16_type best, t;
      int n;
      if (rq.op == OP_LOAD) begin
         cyl_table[rq.slot] = '{rq.px, rq.py, rq.pz, rq.vx, rq.vy, rq.vz, rq.radius};
         return;
      end
      res = '{1'b0, 4'd0, 31'd0};
      best = q16_type'({1'b0, rq.prior});
      n = (cyl_count > NUM_SLOTS) ? NUM_SLOTS : cyl_count;
      for (int k = 0; k < n; k++) begin
         if (cylinder_closer(k, rq, best, t)) begin
            best = t;
            res.hit = 1'b1;
            res.idx = 4'(k);
         end
      end
      res.distance = best[30:0];
      expected_hits.push_back(res);
   endtask

   // ---------------- stimulus ----------------
   function automatic q16_type near_coord(input int span);
      return q16_type'($urandom_range(0, 2 * span * ONE)) - q16_type'(span * ONE);
   endfunction

   function automatic request_type load_req(input logic [3:0] slot, input q16_type bx, by, bz,
                                            input q16_type ax, ay, az, input logic [30:0] r);
      request_type rq;
      rq = '{OP_LOAD, slot, bx, by, bz, ax, ay, az, r, 31'($urandom())};
      return rq;
   endfunction

   function automatic request_type trace_req(input q16_type px, py, pz,
                                             input q16_type vx, vy, vz,
                                             input logic [30:0] prior);
      request_type rq;
      rq = '{OP_TRACE, 4'($urandom()), px, py, pz, vx, vy, vz, 31'($urandom()), prior};
      return rq;
   endfunction

   function automatic request_type nice_cylinder(input logic [3:0] slot);
      q16_type bx, by, bz;
      bx = near_coord(20);
      by = near_coord(20);
      bz = near_coord(20);
      return load_req(slot, bx, by, bz, bx + near_coord(4), by + near_coord(4),
                      bz + near_coord(4), 31'($urandom_range(ONE / 4, 6 * ONE)));
   endfunction

   function automatic request_type random_request();
      int pick;
      q16_type px, py, pz;
      logic [30:0] prior;
      pick = $urandom_range(99);
      if (pick < 25) return nice_cylinder(4'($urandom()));
      if (pick < 30)
         return load_req(4'($urandom()), $urandom(), $urandom(), $urandom(), $urandom(),
                         $urandom(), $urandom(), 31'($urandom()));
      if (pick < 88) begin
         // aim roughly at the populated box so intersections are common
         px = near_coord(40);
         py = near_coord(40);
         pz = near_coord(40);
         prior = ($urandom_range(3) == 0) ? 31'($urandom()) : 31'h7FFF_FFFF;
         return trace_req(px, py, pz, (near_coord(10) - px) >>> $urandom_range(2, 5),
                          (near_coord(10) - py) >>> $urandom_range(2, 5),
                          (near_coord(10) - pz) >>> $urandom_range(2, 5), prior);
      end
      return trace_req($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                       $urandom(), 31'($urandom()));
   endfunction

   task automatic fill_directed();
      pending_requests.push_back(load_req(4'd0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                                          32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0,
                                          31'h7FFF_FFFF));
      // zero-length axis
      pending_requests.push_back(load_req(4'd1, 5 * ONE, 5 * ONE, 0, 5 * ONE, 5 * ONE, 0,
                                          31'(ONE)));
      for (int k = 2; k < NUM_SLOTS; k++) pending_requests.push_back(nice_cylinder(4'(k)));
      // zero direction: denominator vanishes
      pending_requests.push_back(trace_req(0, 0, 0, 0, 0, 0, 31'h7FFF_FFFF));
      pending_requests.push_back(trace_req(-30 * ONE, 0, 0, ONE, 0, 0, 31'd0));
      pending_requests.push_back(trace_req(-30 * ONE, ONE, 0, ONE, 0, 0, 31'h7FFF_FFFF));
      pending_requests.push_back(trace_req(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
                                           32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                                           31'h7FFF_FFFF));
      pending_requests.push_back(trace_req(0, 0, -20 * ONE, 0, 0, ONE, 31'h7FFF_FFFF));
      pending_requests.push_back(trace_req(ONE / 2, ONE / 2, 0, ONE, ONE, ONE, 31'd6554));
      pushed += 22;
   endtask

   // ---------------- driver and monitor ----------------
   always @(negedge clock) begin
      if (!req_valid || req_taken) begin
         if (!reset && pending_requests.size() > 0 &&
             $urandom_range(99) >= send_idle_pct) begin
            request_type rq;
            rq = pending_requests.pop_front();
            req_valid          <= 1'b1;
            req_operation      <= rq.op;
            req_slot           <= rq.slot;
            req_point_x        <= rq.px;
            req_point_y        <= rq.py;
            req_point_z        <= rq.pz;
            req_vector_x       <= rq.vx;
            req_vector_y       <= rq.vy;
            req_vector_z       <= rq.vz;
            req_radius         <= rq.radius;
            req_prior_distance <= rq.prior;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_ready <= !reset && ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      req_taken = req_valid && req_ready;
      if (req_taken) begin
         request_type rq;
         rq = '{op_type'(req_operation), req_slot, req_point_x, req_point_y, req_point_z,
                req_vector_x, req_vector_y, req_vector_z, req_radius, req_prior_distance};
         predict_request(rq);
         accepted++;
      end
      if (!reset && csr_write_enable) cyl_count = csr_write_data;
      if (rsp_valid && rsp_ready) begin
         if (expected_hits.size() == 0) begin
            errors++;
            if (errors <= 10) $display("ERROR: unexpected response hit=%0b idx=%0d dist=%h",
                                       rsp_hit, rsp_cylinder_index, rsp_distance);
         end else begin
            hit_result_type e;
            e = expected_hits.pop_front();
            if (rsp_hit !== e.hit || rsp_cylinder_index !== e.idx ||
                rsp_distance !== e.distance) begin
               errors++;
               if (errors <= 10)
                  $display("ERROR: hit/idx/dist expected %0b/%0d/%h got %0b/%0d/%h",
                           e.hit, e.idx, e.distance, rsp_hit, rsp_cylinder_index,
                           rsp_distance);
            end
         end
      end
      if (req_taken || (rsp_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
         $display("ERROR: watchdog expired");
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ---------------- sequencing ----------------
   task automatic wait_drained();
      while (accepted != pushed || expected_hits.size() != 0) @(negedge clock);
      repeat (DRAIN) @(negedge clock);
   endtask

   task automatic write_count(input logic [4:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      int counts[12] = '{1, 2, 3, 1, 0, 2, 31, 4, 1, 17, 2, 3};
      int sizes[12]  = '{120, 100, 90, 120, 60, 100, 12, 80, 120, 12, 100, 90};
      for (int k = 0; k < NUM_SLOTS; k++) cyl_table[k] = '0;
      cyl_count = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      write_count(5'd16);
      fill_directed();
      wait_drained();
      for (int ph = 0; ph < 12; ph++) begin
         write_count(5'(counts[ph]));
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
            default: begin send_idle_pct = 14; recv_stall_pct = 14; end
         endcase
         for (int i = 0; i < sizes[ph]; i++) pending_requests.push_back(random_request());
         pushed += sizes[ph];
         wait_drained();
      end
      if (errors == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end
endmodule

/* sim.f */
+incdir+sv
sv/rcn_pkg.sv
sv/rcn_sqrt.sv
sv/rcn_div.sv
sv/rcn_datapath.sv
sv/rcn_ctrl.sv
sv/ray_cylinder_nearest_hit.sv
sv/rcn_checker.sv
dv/ray_cylinder_nearest_hit_tb.sv
